/* hdl/ostt_pkg.sv */
package ostt_pkg;

   localparam int NUM_TIMERS = 16;
   // the slot field is four bits wide, so at most sixteen slots are in use
   localparam int SLOT_CAP = 16;
   localparam int USED_SLOTS = (NUM_TIMERS < SLOT_CAP) ? NUM_TIMERS : SLOT_CAP;
   localparam int SLOT_W = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
   localparam int CNT_W = $clog2(USED_SLOTS + 1);

   localparam int TIME_W = 32;
   localparam int STEP_W = 24;
   localparam int SLOT_OUT_W = 4;

   typedef enum logic [0:0] {
      MODE_CREATE = 1'b0,
      MODE_TICK   = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      KIND_CREATED = 2'd0,
      KIND_FULL    = 2'd1,
      KIND_FIRED   = 2'd2,
      KIND_DONE    = 2'd3
   } kind_type;

endpackage

/* hdl/ostt_if.sv */
interface ostt_req_if import ostt_pkg::*; ();
   logic                valid;
   logic                ready;
   mode_type            mode;
   logic [TIME_W-1:0]   wait_time;
   logic [STEP_W-1:0]   time_step;

   modport source (output valid, output mode, output wait_time, output time_step,
                   input ready);
   modport sink (input valid, input mode, input wait_time, input time_step,
                 output ready);
endinterface

interface ostt_rsp_if import ostt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   kind_type              kind;
   logic [SLOT_OUT_W-1:0] slot;
   logic                  last;

   modport source (output valid, output kind, output slot, output last, input ready);
   modport sink (input valid, input kind, input slot, input last, output ready);
endinterface

/* hdl/one_shot_timer_table.sv */
// channel    | direction | payload
// req_chan   | in        | mode, wait_time, time_step
// rsp_chan   | out       | kind, slot, last
//
// a create gives its result in the output register.
// a tick sweeps the timer memory one slot a cycle while the result side keeps
// up, a rate set by the single read port of the timer memory.
// each fired timer and the closing done result take one output transfer each;
// a stalled result side holds the sweep in place.
// reset is synchronous and clears all live bits; wait and elapsed memory is
// not cleared, since the data of slots that are not live is never used.
module one_shot_timer_table import ostt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ostt_req_if.sink    req_chan,
   ostt_rsp_if.source  rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [USED_SLOTS-1:0] live_ff, live_in;

   // each word holds wait time over elapsed time
   logic [2*TIME_W-1:0] mem [USED_SLOTS];
   logic [2*TIME_W-1:0] rd_data_ff;

   logic              rd_en;
   logic [SLOT_W-1:0] rd_addr;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [2*TIME_W-1:0] wr_data;

   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              p1_valid_ff, p1_valid_in;
   logic [SLOT_W-1:0] p1_idx_ff, p1_idx_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              kind_ff, kind_in;
   logic [SLOT_OUT_W-1:0] slot_ff, slot_in;
   logic                  last_ff, last_in;

   logic              out_free;
   logic              req_xfer;
   logic              have_free;
   logic [SLOT_W-1:0] free_idx;
   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] new_elapsed;
   logic [TIME_W-1:0] cur_wait;
   logic              p1_live;
   logic              fire;
   logic              stall;
   logic              issue;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_xfer = req_chan.valid && req_chan.ready;

   // lowest free slot
   always_comb begin
      have_free = 1'b0;
      free_idx = '0;
      for (int i = USED_SLOTS - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            have_free = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   // second sweep stage: add, saturate, compare
   always_comb begin
      cur_wait = rd_data_ff[2*TIME_W-1:TIME_W];
      sum = {1'b0, rd_data_ff[TIME_W-1:0]} + {{(TIME_W + 1 - STEP_W){1'b0}}, step_ff};
      new_elapsed = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      p1_live = live_ff[p1_idx_ff];
      fire = p1_valid_ff && p1_live && (new_elapsed > cur_wait);
      stall = fire && !out_free;
      issue = (state_ff == ST_SCAN) && !stall && (rd_idx_ff < CNT_W'(USED_SLOTS));
   end

   always_comb begin
      state_in = state_ff;
      live_in = live_ff;
      rd_idx_in = rd_idx_ff;
      p1_valid_in = p1_valid_ff;
      p1_idx_in = p1_idx_ff;
      step_in = step_ff;
      rd_en = 1'b0;
      rd_addr = rd_idx_ff[SLOT_W-1:0];
      wr_en = 1'b0;
      wr_addr = p1_idx_ff;
      wr_data = {cur_wait, new_elapsed};
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      kind_in = kind_ff;
      slot_in = slot_ff;
      last_in = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               rsp_valid_in = 1'b1;
               last_in = 1'b1;
               if (req_chan.mode == MODE_CREATE) begin
                  if (have_free) begin
                     live_in[free_idx] = 1'b1;
                     wr_en = 1'b1;
                     wr_addr = free_idx;
                     wr_data = {req_chan.wait_time, {TIME_W{1'b0}}};
                     kind_in = KIND_CREATED;
                     slot_in = SLOT_OUT_W'(free_idx);
                  end else begin
                     kind_in = KIND_FULL;
                     slot_in = '0;
                  end
               end else begin
                  rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
                  state_in = ST_SCAN;
                  step_in = req_chan.time_step;
                  rd_idx_in = '0;
                  p1_valid_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (p1_valid_ff && p1_live) begin
                  wr_en = 1'b1;
               end
               if (fire) begin
                  live_in[p1_idx_ff] = 1'b0;
                  rsp_valid_in = 1'b1;
                  kind_in = KIND_FIRED;
                  slot_in = SLOT_OUT_W'(p1_idx_ff);
                  last_in = 1'b0;
               end
               p1_valid_in = issue;
               if (issue) begin
                  rd_en = 1'b1;
                  p1_idx_in = rd_idx_ff[SLOT_W-1:0];
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in = KIND_DONE;
               slot_in = '0;
               last_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         live_ff <= '0;
         rsp_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         rd_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         live_ff <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_valid_ff <= p1_valid_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_idx_ff <= p1_idx_in;
      step_ff <= step_in;
      kind_ff <= kind_in;
      slot_ff <= slot_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.kind = kind_ff;
   assign rsp_chan.slot = slot_ff;
   assign rsp_chan.last = last_ff;

   a_tick_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_chan.mode == MODE_TICK) |=> state_ff == ST_SCAN)
      else $error("tick transfer did not start a sweep");

   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_FIRED) |-> !last_ff)
      else $error("fired result marked last");

   a_stall_holds_data: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(rd_data_ff) && p1_valid_ff && $stable(p1_idx_ff))
      else $error("sweep stage moved while stalled");

   a_sweep_no_new_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> $countones(live_ff) <= $countones($past(live_ff)))
      else $error("timer became live during a sweep");

endmodule
